/* rtl/core/lzbf_pkg.sv */
package lzbf_pkg;

    localparam int OffsetW  = 14;
    localparam int LenW     = 9;
    localparam int CountW   = 4;
    localparam int MaxLanes = 8;

    localparam logic [OffsetW-1:0] LongBase  = 14'd8192;
    localparam logic [OffsetW-1:0] ShortBase = 14'd256;

    // parse position inside the compressed stream
    typedef enum logic [3:0] {
        PH_FLAG  = 4'd0,
        PH_FLAG2 = 4'd1,
        PH_SBIT1 = 4'd2,
        PH_SBIT2 = 4'd3,
        PH_LIT   = 4'd4,
        PH_LLO   = 4'd5,
        PH_LHI   = 4'd6,
        PH_LLEN  = 4'd7,
        PH_SOFF  = 4'd8
    } t_phase;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CP_RD,
        ST_CP_WR,
        ST_LIT_WR,
        ST_ADVANCE,
        ST_FINAL
    } t_state;

    typedef struct packed {
        logic               wr_en;
        logic [7:0]         wr_data;
        logic               rd_en;
        logic [OffsetW-1:0] rd_offset;
    } t_hist_req;

endpackage

/* rtl/core/lz_bitflag_decompressor_unit.sv */
// flag-bit lz77 decompressor, one compressed byte per input item
// input channel: i_in_valid / o_in_ready with i_in_byte
// output channel: o_out_valid / i_out_ready with o_out_bytes, o_byte_count,
//   o_run_last and o_stream_end; each result packs up to OUT_LANES decoded
//   bytes, first byte in bits 7..0, unused lanes zero
// an input byte yields zero or more results; the last one has o_run_last set
// the end marker gives one result with o_stream_end set and no bytes
// sequence: the idle state takes the byte, the decode state decodes it, a literal
//   is written and packed, each copied match byte is a history read, then a write
//   and pack, each control bit consumed is one advance step, then the bit loop
//   is left and the final state posts the result
// the sequencer steps through these states in order; the block takes a new byte
//   only once the previous one is fully worked off
// a full output register that is not taken stalls the sequencer; an accepted
//   input is never lost
// reset: synchronous, active low; parser returns to await a control word,
//   history reads as zero until written (write count tracking, no clear pass)
module lz_bitflag_decompressor_unit #(
    parameter int WINDOW_SIZE = 8192,
    parameter int OUT_LANES   = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_out_bytes,
    output logic [3:0]  o_byte_count,
    output logic        o_run_last,
    output logic        o_stream_end
);

    localparam int CW = lzbf_pkg::CountW;
    localparam int OW = lzbf_pkg::OffsetW;
    localparam int LW = lzbf_pkg::LenW;
    localparam logic [CW-1:0] LaneMax = CW'(OUT_LANES);

    lzbf_pkg::t_state r_state, n_state;
    lzbf_pkg::t_phase r_phase, n_phase;

    logic [7:0]    r_byte;
    logic [31:0]   r_queue, n_queue;
    logic [5:0]    r_bits, n_bits;
    logic [23:0]   r_gather, n_gather;
    logic [1:0]    r_gcnt, n_gcnt;
    logic [LW-1:0] r_len, n_len;
    logic [OW-1:0] r_off, n_off;
    logic          r_ended, n_ended;
    logic [63:0]   r_lane, n_lane;
    logic [CW-1:0] r_lane_n, n_lane_n;

    logic          r_out_valid, n_out_valid;
    logic [63:0]   r_out_bytes, n_out_bytes;
    logic [CW-1:0] r_out_count, n_out_count;
    logic          r_out_last, n_out_last;
    logic          r_out_end, n_out_end;

    lzbf_pkg::t_hist_req hist_req;
    logic [7:0]          hist_rd;

    logic          out_free;
    logic          lane_full;
    logic          emit_stall;
    logic          adv_go;
    logic          adv_bit;
    logic [7:0]    emit_data;
    logic [15:0]   long_word;
    logic [CW-1:0] lane_pos;

    lzbf_history #(
        .WINDOW_SIZE(WINDOW_SIZE)
    ) u_history (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (hist_req),
        .o_rd_data(hist_rd)
    );

    always_comb begin
        out_free   = !r_out_valid || i_out_ready;
        lane_full  = (r_lane_n == LaneMax);
        emit_stall = lane_full && !out_free;
        adv_go     = (r_bits != 6'd0) &&
                     ((r_phase == lzbf_pkg::PH_FLAG)  || (r_phase == lzbf_pkg::PH_FLAG2) ||
                      (r_phase == lzbf_pkg::PH_SBIT1) || (r_phase == lzbf_pkg::PH_SBIT2));
        adv_bit    = r_queue[5'(r_bits - 6'd1)];
        emit_data  = (r_state == lzbf_pkg::ST_LIT_WR) ? r_byte : hist_rd;
        long_word  = {r_byte, r_gather[7:0]};
        lane_pos   = lane_full ? '0 : r_lane_n;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lzbf_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = lzbf_pkg::ST_DECODE;
                end
            end
            lzbf_pkg::ST_DECODE: begin
                case (r_phase)
                    lzbf_pkg::PH_LIT: n_state = lzbf_pkg::ST_LIT_WR;
                    lzbf_pkg::PH_LHI: begin
                        n_state = (long_word[2:0] == 3'd0) ? lzbf_pkg::ST_ADVANCE
                                                           : lzbf_pkg::ST_CP_RD;
                    end
                    lzbf_pkg::PH_LLEN: begin
                        n_state = (r_byte == 8'd0) ? lzbf_pkg::ST_ADVANCE
                                                   : lzbf_pkg::ST_CP_RD;
                    end
                    lzbf_pkg::PH_SOFF: n_state = lzbf_pkg::ST_CP_RD;
                    default:           n_state = lzbf_pkg::ST_ADVANCE;
                endcase
            end
            lzbf_pkg::ST_CP_RD: n_state = lzbf_pkg::ST_CP_WR;
            lzbf_pkg::ST_CP_WR: begin
                if (!emit_stall) begin
                    n_state = (r_len == LW'(1)) ? lzbf_pkg::ST_ADVANCE : lzbf_pkg::ST_CP_RD;
                end
            end
            lzbf_pkg::ST_LIT_WR: begin
                if (!emit_stall) begin
                    n_state = lzbf_pkg::ST_ADVANCE;
                end
            end
            lzbf_pkg::ST_ADVANCE: begin
                if (!adv_go || r_ended) begin
                    n_state = lzbf_pkg::ST_FINAL;
                end
            end
            lzbf_pkg::ST_FINAL: begin
                if (out_free || (!r_ended && r_lane_n == '0)) begin
                    n_state = lzbf_pkg::ST_IDLE;
                end
            end
            default: n_state = lzbf_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_phase     = r_phase;
        n_queue     = r_queue;
        n_bits      = r_bits;
        n_gather    = r_gather;
        n_gcnt      = r_gcnt;
        n_len       = r_len;
        n_off       = r_off;
        n_ended     = r_ended;
        n_lane      = r_lane;
        n_lane_n    = r_lane_n;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_bytes = r_out_bytes;
        n_out_count = r_out_count;
        n_out_last  = r_out_last;
        n_out_end   = r_out_end;
        hist_req    = '0;
        o_in_ready  = 1'b0;

        unique case (r_state)
            lzbf_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            lzbf_pkg::ST_DECODE: begin
                n_ended  = 1'b0;
                n_lane   = '0;
                n_lane_n = '0;
                case (r_phase)
                    lzbf_pkg::PH_LIT: n_phase = lzbf_pkg::PH_FLAG;
                    lzbf_pkg::PH_LLO: begin
                        n_gather = {16'd0, r_byte};
                        n_phase  = lzbf_pkg::PH_LHI;
                    end
                    lzbf_pkg::PH_LHI: begin
                        n_gather = '0;
                        n_off    = lzbf_pkg::LongBase - {1'b0, long_word[15:3]};
                        if (long_word[2:0] == 3'd0) begin
                            n_phase = lzbf_pkg::PH_LLEN;
                        end else begin
                            n_len   = LW'(long_word[2:0]) + LW'(2);
                            n_phase = lzbf_pkg::PH_FLAG;
                        end
                    end
                    lzbf_pkg::PH_LLEN: begin
                        if (r_byte == 8'd0) begin
                            // end marker: drop held control bits
                            n_ended  = 1'b1;
                            n_bits   = '0;
                            n_queue  = '0;
                            n_gcnt   = '0;
                            n_gather = '0;
                            n_len    = '0;
                        end else begin
                            n_len = LW'(r_byte) + LW'(2);
                        end
                        n_phase = lzbf_pkg::PH_FLAG;
                    end
                    lzbf_pkg::PH_SOFF: begin
                        n_off   = lzbf_pkg::ShortBase - OW'(r_byte);
                        n_len   = LW'(r_len[1:0]) + LW'(2);
                        n_phase = lzbf_pkg::PH_FLAG;
                    end
                    default: begin
                        // byte belongs to a control word
                        if (!(r_phase inside {lzbf_pkg::PH_FLAG, lzbf_pkg::PH_FLAG2,
                                              lzbf_pkg::PH_SBIT1, lzbf_pkg::PH_SBIT2})) begin
                            n_phase = lzbf_pkg::PH_FLAG;
                        end
                        if (r_gcnt != 2'd3) begin
                            n_gather = r_gather | (24'(r_byte) << {r_gcnt, 3'b000});
                            n_gcnt   = r_gcnt + 2'd1;
                        end else begin
                            n_queue  = {r_byte, r_gather};
                            n_bits   = 6'd32;
                            n_gcnt   = '0;
                            n_gather = '0;
                        end
                    end
                endcase
            end
            lzbf_pkg::ST_CP_RD: begin
                hist_req.rd_en     = 1'b1;
                hist_req.rd_offset = r_off;
            end
            lzbf_pkg::ST_CP_WR, lzbf_pkg::ST_LIT_WR: begin
                if (!emit_stall) begin
                    hist_req.wr_en   = 1'b1;
                    hist_req.wr_data = emit_data;
                    if (lane_full) begin
                        n_out_valid = 1'b1;
                        n_out_bytes = r_lane;
                        n_out_count = r_lane_n;
                        n_out_last  = 1'b0;
                        n_out_end   = 1'b0;
                        n_lane      = '0;
                    end
                    for (int i = 0; i < OUT_LANES; i++) begin
                        if (CW'(i) == lane_pos) begin
                            n_lane[8*i +: 8] = emit_data;
                        end
                    end
                    n_lane_n = lane_pos + CW'(1);
                    if (r_state == lzbf_pkg::ST_CP_WR) begin
                        n_len = r_len - LW'(1);
                    end
                end
            end
            lzbf_pkg::ST_ADVANCE: begin
                if (adv_go && !r_ended) begin
                    n_bits = r_bits - 6'd1;
                    case (r_phase)
                        lzbf_pkg::PH_FLAG: begin
                            n_phase = adv_bit ? lzbf_pkg::PH_LIT : lzbf_pkg::PH_FLAG2;
                        end
                        lzbf_pkg::PH_FLAG2: begin
                            n_phase = adv_bit ? lzbf_pkg::PH_LLO : lzbf_pkg::PH_SBIT1;
                        end
                        lzbf_pkg::PH_SBIT1: begin
                            n_len   = {{(LW-2){1'b0}}, adv_bit, 1'b0};
                            n_phase = lzbf_pkg::PH_SBIT2;
                        end
                        default: begin
                            n_len   = r_len + LW'(adv_bit);
                            n_phase = lzbf_pkg::PH_SOFF;
                        end
                    endcase
                end
            end
            lzbf_pkg::ST_FINAL: begin
                if (out_free && (r_ended || r_lane_n != '0)) begin
                    n_out_valid = 1'b1;
                    n_out_bytes = r_ended ? 64'd0 : r_lane;
                    n_out_count = r_ended ? '0 : r_lane_n;
                    n_out_last  = 1'b1;
                    n_out_end   = r_ended;
                    n_lane      = '0;
                    n_lane_n    = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_byte <= i_in_byte;
        end
        r_out_bytes <= n_out_bytes;
        r_out_count <= n_out_count;
        r_out_last  <= n_out_last;
        r_out_end   <= n_out_end;
        if (!i_rst_n) begin
            r_state     <= lzbf_pkg::ST_IDLE;
            r_phase     <= lzbf_pkg::PH_FLAG;
            r_bits      <= '0;
            r_gcnt      <= '0;
            r_ended     <= 1'b0;
            r_lane_n    <= '0;
            r_out_valid <= 1'b0;
            r_queue     <= '0;
            r_gather    <= '0;
            r_len       <= '0;
            r_off       <= '0;
            r_lane      <= '0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_bits      <= n_bits;
            r_gcnt      <= n_gcnt;
            r_ended     <= n_ended;
            r_lane_n    <= n_lane_n;
            r_out_valid <= n_out_valid;
            r_queue     <= n_queue;
            r_gather    <= n_gather;
            r_len       <= n_len;
            r_off       <= n_off;
            r_lane      <= n_lane;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_bytes  = r_out_bytes;
    assign o_byte_count = r_out_count;
    assign o_run_last   = r_out_last;
    assign o_stream_end = r_out_end;

endmodule

/* rtl/core/lzbf_history.sv */
module lzbf_history #(
    parameter int WINDOW_SIZE = 8192
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lzbf_pkg::t_hist_req   i_req,
    output logic [7:0]            o_rd_data
);

    localparam int PosW = $clog2(WINDOW_SIZE);
    localparam logic [PosW-1:0] LastPos = PosW'(WINDOW_SIZE - 1);
    localparam logic [PosW:0]   WinExt  = (PosW+1)'(WINDOW_SIZE);

    logic [7:0]      mem [WINDOW_SIZE];
    logic [PosW-1:0] r_wpos;
    logic            r_wrapped;
    logic [7:0]      r_rd_data;
    logic            r_rd_ok;

    logic [PosW:0]   wpos_ext;
    logic [PosW:0]   off_ext;
    logic [PosW:0]   src_ext;
    logic [PosW-1:0] src;
    logic            src_ok;

    always_comb begin
        wpos_ext = {1'b0, r_wpos};
        off_ext  = (PosW+1)'(i_req.rd_offset);
        if (wpos_ext >= off_ext) begin
            src_ext = wpos_ext - off_ext;
        end else begin
            src_ext = wpos_ext + WinExt - off_ext;
        end
        src    = src_ext[PosW-1:0];
        // entries not yet written since reset read as zero
        src_ok = r_wrapped || (src < r_wpos);
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[r_wpos] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= mem[src];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos    <= '0;
            r_wrapped <= 1'b0;
            r_rd_ok   <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                if (r_wpos == LastPos) begin
                    r_wpos    <= '0;
                    r_wrapped <= 1'b1;
                end else begin
                    r_wpos <= r_wpos + 1'b1;
                end
            end
            if (i_req.rd_en) begin
                r_rd_ok <= src_ok;
            end
        end
    end

    assign o_rd_data = r_rd_ok ? r_rd_data : 8'd0;

endmodule

/* rtl/core/lzbf_checker.sv */
module lzbf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [7:0]  i_in_byte,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [63:0] o_out_bytes,
    input logic [3:0]  o_byte_count,
    input logic        o_run_last,
    input logic        o_stream_end
);

    // end marker result carries no bytes and closes its item
    a_end_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_stream_end |-> o_byte_count == 4'd0 && o_out_bytes == 64'd0
            && o_run_last)
        else $error("end marker result not empty or not last");

    // a data result always holds between one and the lane count bytes
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_stream_end |-> o_byte_count != 4'd0
            && o_byte_count <= 4'(lzbf_pkg::MaxLanes))
        else $error("byte count out of range");

    // one item at a time: no new item the cycle after one is taken
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after an accepted item");

    // lanes above the count are zero
    a_lanes_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_byte_count < 4'd8 && o_byte_count != 4'd0 |->
            (o_out_bytes >> {o_byte_count, 3'b000}) == 64'd0)
        else $error("bytes above the count not zero");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_bytes)
            && $stable(o_byte_count) && $stable(o_run_last) && $stable(o_stream_end))
        else $error("stalled result changed");

endmodule

bind lz_bitflag_decompressor_unit lzbf_checker u_lzbf_checker (.*);

/* dv/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW      = 8192;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 600;
    localparam int PRINT_CAP   = 50;

    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  count;
        logic        last;
        logic        marker;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_in_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [63:0] o_out_bytes;
    logic [3:0]  o_byte_count;
    logic        o_run_last;
    logic        o_stream_end;

    lz_bitflag_decompressor_unit uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_byte    (i_in_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_bytes  (o_out_bytes),
        .o_byte_count (o_byte_count),
        .o_run_last   (o_run_last),
        .o_stream_end (o_stream_end)
    );

    // decoder shadow state
    logic [31:0]      flag_word;
    int               flags_left;
    lzbf_pkg::t_phase parse_ph;
    logic [23:0]      gather;
    int               gather_n;
    int               copy_len;
    int               copy_dist;
    logic [7:0]       window_mem [WINDOW];
    int               wr_pos;
    logic [63:0]      lane_acc;
    int               lane_n;
    t_result          decoded_q[$];

    // compressed stream under construction
    logic [7:0]  comp_q[$];
    int          ctrl_pos;
    int          ctrl_used;

    int  mismatch_cnt;
    int  quiet_cycles;
    bit  send_idle_en;
    bit  recv_stall_en;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        mismatch_cnt++;
        if (mismatch_cnt <= PRINT_CAP) $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // ---------------------------------------------------------------- predictor

    function automatic void flush_lanes();
        t_result r;
        if (lane_n == 0) return;
        r.data   = lane_acc;
        r.count  = 4'(lane_n);
        r.last   = 1'b0;
        r.marker = 1'b0;
        decoded_q.push_back(r);
        lane_acc = '0;
        lane_n   = 0;
    endfunction

    function automatic void put_decoded(input logic [7:0] b);
        window_mem[wr_pos] = b;
        wr_pos = (wr_pos + 1) % WINDOW;
        lane_acc |= 64'(b) << (8 * lane_n);
        lane_n++;
        if (lane_n >= lzbf_pkg::MaxLanes) flush_lanes();
    endfunction

    function automatic void copy_back();
        int src;
        for (int k = 0; k < copy_len; k++) begin
            src = (wr_pos + WINDOW - copy_dist) % WINDOW;
            put_decoded(window_mem[src]);
        end
    endfunction

    function automatic logic pop_flag();
        flags_left--;
        return flag_word[flags_left];
    endfunction

    // consume control bits until the parser needs a byte
    function automatic void run_flags();
        while (parse_ph <= lzbf_pkg::PH_SBIT2 && flags_left != 0) begin
            case (parse_ph)
                lzbf_pkg::PH_FLAG: begin
                    parse_ph = pop_flag() ? lzbf_pkg::PH_LIT : lzbf_pkg::PH_FLAG2;
                end
                lzbf_pkg::PH_FLAG2: begin
                    parse_ph = pop_flag() ? lzbf_pkg::PH_LLO : lzbf_pkg::PH_SBIT1;
                end
                lzbf_pkg::PH_SBIT1: begin
                    copy_len = pop_flag() ? 2 : 0;
                    parse_ph = lzbf_pkg::PH_SBIT2;
                end
                default: begin
                    copy_len += int'(pop_flag());
                    parse_ph = lzbf_pkg::PH_SOFF;
                end
            endcase
        end
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        bit          ended;
        int          n0;
        logic [15:0] w;
        t_result     r;
        ended    = 1'b0;
        n0       = decoded_q.size();
        lane_acc = '0;
        lane_n   = 0;
        case (parse_ph)
            lzbf_pkg::PH_LIT: begin
                put_decoded(b);
                parse_ph = lzbf_pkg::PH_FLAG;
            end
            lzbf_pkg::PH_LLO: begin
                gather   = {16'd0, b};
                parse_ph = lzbf_pkg::PH_LHI;
            end
            lzbf_pkg::PH_LHI: begin
                w         = {b, gather[7:0]};
                gather    = '0;
                copy_dist = 8192 - int'(w[15:3]);
                if (w[2:0] == 3'd0) begin
                    parse_ph = lzbf_pkg::PH_LLEN;
                end else begin
                    copy_len = int'(w[2:0]) + 2;
                    copy_back();
                    parse_ph = lzbf_pkg::PH_FLAG;
                end
            end
            lzbf_pkg::PH_LLEN: begin
                if (b == 8'd0) begin
                    // end marker drops whatever control bits remain
                    ended      = 1'b1;
                    flags_left = 0;
                    flag_word  = '0;
                    gather_n   = 0;
                    gather     = '0;
                    copy_len   = 0;
                end else begin
                    copy_len = int'(b) + 2;
                    copy_back();
                end
                parse_ph = lzbf_pkg::PH_FLAG;
            end
            lzbf_pkg::PH_SOFF: begin
                copy_dist = 256 - int'(b);
                copy_len  = (copy_len & 3) + 2;
                copy_back();
                parse_ph = lzbf_pkg::PH_FLAG;
            end
            default: begin
                // flag needed and none left: this is a control word byte
                if (gather_n < 3) begin
                    gather[8*gather_n +: 8] = b;
                    gather_n++;
                end else begin
                    flag_word  = {b, gather};
                    flags_left = 32;
                    gather_n   = 0;
                    gather     = '0;
                end
            end
        endcase
        if (!ended) run_flags();
        flush_lanes();
        if (ended) begin
            r = '0;
            r.marker = 1'b1;
            decoded_q.push_back(r);
        end
        if (decoded_q.size() > n0) begin
            r = decoded_q.pop_back();
            r.last = 1'b1;
            decoded_q.push_back(r);
        end
    endfunction

    task automatic clear_decoder();
        flag_word  = '0;
        flags_left = 0;
        parse_ph   = lzbf_pkg::PH_FLAG;
        gather     = '0;
        gather_n   = 0;
        copy_len   = 0;
        copy_dist  = 0;
        wr_pos     = 0;
        for (int i = 0; i < WINDOW; i++) window_mem[i] = 8'h00;
    endtask

    // ---------------------------------------------------------------- stream encoder

    task automatic enc_flag(input bit v);
        logic [7:0] t;
        int         pos;
        if (ctrl_used == 32) begin
            ctrl_pos = comp_q.size();
            repeat (4) comp_q.push_back(8'h00);
            ctrl_used = 0;
        end
        pos = 31 - ctrl_used;
        t = comp_q[ctrl_pos + pos / 8];
        t[pos % 8] = v;
        comp_q[ctrl_pos + pos / 8] = t;
        ctrl_used++;
    endtask

    task automatic enc_literal(input logic [7:0] b);
        enc_flag(1'b1);
        comp_q.push_back(b);
    endtask

    task automatic enc_short(input logic [1:0] len, input logic [7:0] off);
        enc_flag(1'b0);
        enc_flag(1'b0);
        enc_flag(len[1]);
        enc_flag(len[0]);
        comp_q.push_back(off);
    endtask

    // field is 8192 - distance
    task automatic enc_long(input logic [12:0] field, input logic [2:0] len);
        logic [15:0] w;
        enc_flag(1'b0);
        enc_flag(1'b1);
        w = {field, len};
        comp_q.push_back(w[7:0]);
        comp_q.push_back(w[15:8]);
    endtask

    task automatic enc_long_ext(input logic [12:0] field, input logic [7:0] ext);
        enc_long(field, 3'd0);
        comp_q.push_back(ext);
    endtask

    task automatic enc_end(input logic [12:0] field);
        enc_long_ext(field, 8'd0);
        ctrl_used = 32;
    endtask

    function automatic logic [12:0] pick_field();
        if ($urandom_range(99) < 70) return 13'(8192 - $urandom_range(1, 64));
        return 13'($urandom_range(0, 8191));
    endfunction

    task automatic build_random_stream(input int max_tokens);
        int ntok;
        int sel;
        ntok = $urandom_range(1, max_tokens);
        repeat (ntok) begin
            sel = $urandom_range(99);
            if (sel < 40) begin
                enc_literal(8'($urandom));
            end else if (sel < 70) begin
                enc_short(2'($urandom_range(3)), 8'($urandom));
            end else if (sel < 90) begin
                enc_long(pick_field(), 3'($urandom_range(1, 7)));
            end else begin
                enc_long_ext(pick_field(), ($urandom_range(3) == 0) ?
                             8'($urandom_range(1, 255)) : 8'($urandom_range(1, 20)));
            end
        end
    endtask

    // ---------------------------------------------------------------- channels

    task automatic send_byte(input logic [7:0] b);
        while (send_idle_en && $urandom_range(99) < 29) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_byte  = b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        decode_byte(b);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic feed_stream();
        foreach (comp_q[i]) send_byte(comp_q[i]);
        comp_q.delete();
    endtask

    always @(negedge i_clk) begin
        if (recv_stall_en) i_out_ready <= ($urandom_range(99) >= 29);
        else i_out_ready <= 1'b1;
    end

    task automatic check_result();
        t_result want;
        if (decoded_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result bytes=%h count=%0d",
                                      o_out_bytes, o_byte_count));
            return;
        end
        want = decoded_q.pop_front();
        if (o_out_bytes !== want.data)
            report_mismatch($sformatf("out_bytes %h, predicted %h", o_out_bytes, want.data));
        if (o_byte_count !== want.count)
            report_mismatch($sformatf("byte_count %0d, predicted %0d",
                                      o_byte_count, want.count));
        if (o_run_last !== want.last)
            report_mismatch($sformatf("run_last %b, predicted %b", o_run_last, want.last));
        if (o_stream_end !== want.marker)
            report_mismatch($sformatf("stream_end %b, predicted %b",
                                      o_stream_end, want.marker));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) check_result();
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------------------------------------------------------- tests

    // must run first: copies reach into history that was never written
    task automatic test_cold_history();
        enc_short(2'd3, 8'h00);
        enc_literal(8'h00);
        enc_literal(8'hFF);
        enc_long(13'd8191, 3'd7);
        enc_long(13'd0, 3'd1);
        enc_long_ext(13'd8189, 8'd255);
        enc_end(13'd0);
        feed_stream();
    endtask

    // new stream after an end marker, copying from the previous stream's output
    task automatic test_stream_restart();
        enc_long_ext(13'd7892, 8'd1);
        enc_short(2'd0, 8'hFF);
        enc_short(2'd1, 8'($urandom));
        enc_short(2'd2, 8'($urandom));
        enc_short(2'd3, 8'($urandom));
        enc_end(13'($urandom));
        feed_stream();
    endtask

    task automatic test_random_streams(input int n_bytes);
        int fed;
        fed = 0;
        while (fed < n_bytes) begin
            build_random_stream(40);
            enc_end(13'($urandom));
            fed += comp_q.size();
            feed_stream();
        end
    endtask

    task automatic test_back_to_back(input int n_bytes);
        send_idle_en  = 1'b0;
        recv_stall_en = 1'b0;
        test_random_streams(n_bytes);
        send_idle_en  = 1'b1;
        recv_stall_en = 1'b1;
    endtask

    // stream cut off at a random point, no end marker
    task automatic test_truncated_stream();
        int cut;
        build_random_stream(12);
        cut = $urandom_range(1, comp_q.size());
        while (comp_q.size() > cut) void'(comp_q.pop_back());
        feed_stream();
    endtask

    task automatic test_noise_bytes(input int n_bytes);
        repeat (n_bytes) begin
            if ($urandom_range(3) == 0) send_byte(8'h00);
            else send_byte(8'($urandom));
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_byte     = 8'h00;
        i_out_ready   = 1'b0;
        mismatch_cnt  = 0;
        quiet_cycles  = 0;
        send_idle_en  = 1'b1;
        recv_stall_en = 1'b1;
        ctrl_pos      = 0;
        ctrl_used     = 32;
        lane_acc      = '0;
        lane_n        = 0;
        clear_decoder();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_cold_history();
        test_stream_restart();
        test_random_streams(200);
        test_back_to_back(100);
        test_random_streams(80);
        test_truncated_stream();
        test_noise_bytes(48);

        i_in_valid = 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
